// File: rtl/core/slsfr_pkg.sv
// package: shared types and constants for the sync/length/sum frame receiver
`default_nettype none

package slsfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h0F;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

    localparam logic [WORD_W-1:0] MIN_LENGTH = 16'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYNC = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_OK       = 2'd1,
        KIND_CHECKERR = 2'd2,
        KIND_LENERR   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] byte_value;
        logic [WORD_W-1:0] frame_length;
        logic [WORD_W-1:0] computed_sum;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/slsfr_in_if.sv
// interface: received byte channel
`default_nettype none

interface slsfr_in_if;
    logic                      valid;
    logic                      ready;
    logic [slsfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slsfr_out_if.sv
// interface: result channel
`default_nettype none

interface slsfr_out_if;
    logic                         valid;
    logic                         ready;
    slsfr_pkg::kind_t             kind;
    logic [slsfr_pkg::BYTE_W-1:0] byte_value;
    logic [slsfr_pkg::WORD_W-1:0] frame_length;
    logic [slsfr_pkg::WORD_W-1:0] computed_sum;

    modport source (output valid, output kind, output byte_value, output frame_length,
                    output computed_sum, input ready);
    modport sink   (input valid, input kind, input byte_value, input frame_length,
                    input computed_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slsfr_in_stage.sv
// input register for received bytes
`default_nettype none

module slsfr_in_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    slsfr_in_if.sink                          in_ch,
    input  wire logic                         advance,
    output logic                              byte_valid,
    output logic [slsfr_pkg::BYTE_W-1:0]      byte_data
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [slsfr_pkg::BYTE_W-1:0] byte_reg;
    logic                         load;

    // register is free when empty or its byte moves on this cycle
    assign in_ch.ready = !valid_reg || advance;
    assign load        = in_ch.valid && in_ch.ready;
    assign valid_next  = in_ch.ready ? in_ch.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_ch.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

// File: rtl/core/slsfr_parser.sv
// frame parser: sync hunt, length, running sum and checksum compare
`default_nettype none

module slsfr_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [slsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [slsfr_pkg::BYTE_W-1:0]      cfg_data,
    input  wire logic                              fire,
    input  wire logic [slsfr_pkg::BYTE_W-1:0]      byte_data,
    output logic                                   res_valid,
    output slsfr_pkg::result_t                     res
);

    logic [slsfr_pkg::BYTE_W-1:0] sync_first_reg;
    logic [slsfr_pkg::BYTE_W-1:0] sync_second_reg;

    slsfr_pkg::phase_t            phase_reg,     phase_next;
    logic                         seen_reg,      seen_next;
    logic [slsfr_pkg::WORD_W-1:0] length_reg,    length_next;
    logic [slsfr_pkg::WORD_W-1:0] count_reg,     count_next;
    logic [slsfr_pkg::WORD_W-1:0] sum_reg,       sum_next;
    logic [slsfr_pkg::BYTE_W-1:0] check_reg,     check_next;

    logic [slsfr_pkg::WORD_W-1:0] sum_after;
    logic [slsfr_pkg::WORD_W-1:0] full_length;
    logic [slsfr_pkg::WORD_W:0]   count_plus2;
    logic [slsfr_pkg::WORD_W:0]   length_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slsfr_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slsfr_pkg::SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slsfr_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                slsfr_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sum_after   = sum_reg + {{(slsfr_pkg::WORD_W-slsfr_pkg::BYTE_W){1'b0}}, byte_data};
    assign full_length = {length_reg[slsfr_pkg::BYTE_W-1:0], byte_data};
    assign count_plus2 = {1'b0, count_reg} + 17'd2;
    assign length_ext  = {1'b0, length_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        check_next  = check_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (fire)
        begin
            unique case (phase_reg)
                slsfr_pkg::PH_IDLE:
                begin
                    if (byte_data == sync_first_reg)
                    begin
                        phase_next = slsfr_pkg::PH_SYNC;
                        sum_next   = sum_after;
                    end
                end

                slsfr_pkg::PH_SYNC:
                begin
                    if (byte_data == sync_second_reg)
                    begin
                        phase_next = slsfr_pkg::PH_LEN;
                        sum_next   = sum_after;
                    end
                    else
                    begin
                        phase_next = slsfr_pkg::PH_IDLE;
                        sum_next   = '0;
                    end
                end

                slsfr_pkg::PH_LEN:
                begin
                    sum_next = sum_after;
                    if (!seen_reg)
                    begin
                        length_next = {{(slsfr_pkg::WORD_W-slsfr_pkg::BYTE_W){1'b0}}, byte_data};
                        seen_next   = 1'b1;
                    end
                    else
                    begin
                        seen_next  = 1'b0;
                        count_next = '0;
                        if (full_length < slsfr_pkg::MIN_LENGTH)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = slsfr_pkg::KIND_LENERR;
                            res.frame_length = full_length;
                            res.computed_sum = sum_after;
                            phase_next       = slsfr_pkg::PH_IDLE;
                            length_next      = '0;
                            sum_next         = '0;
                            check_next       = '0;
                        end
                        else
                        begin
                            phase_next  = slsfr_pkg::PH_BODY;
                            length_next = full_length;
                        end
                    end
                end

                slsfr_pkg::PH_BODY:
                begin
                    if (count_plus2 < length_ext)
                    begin
                        sum_next       = sum_after;
                        count_next     = count_reg + 16'd1;
                        res_valid      = 1'b1;
                        res.kind       = slsfr_pkg::KIND_PAYLOAD;
                        res.byte_value = byte_data;
                    end
                    else if (count_plus2 == length_ext)
                    begin
                        // high checksum byte, held until the low one arrives
                        check_next = byte_data;
                        count_next = count_reg + 16'd1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = ({check_reg, byte_data} == sum_reg)
                                           ? slsfr_pkg::KIND_OK : slsfr_pkg::KIND_CHECKERR;
                        res.frame_length = length_reg;
                        res.computed_sum = sum_reg;
                        phase_next       = slsfr_pkg::PH_IDLE;
                        seen_next        = 1'b0;
                        length_next      = '0;
                        count_next       = '0;
                        sum_next         = '0;
                        check_next       = '0;
                    end
                end

                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= slsfr_pkg::PH_IDLE;
            seen_reg   <= 1'b0;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            check_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            check_reg  <= check_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/slsfr_out_stage.sv
// result register toward the output channel
`default_nettype none

module slsfr_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire slsfr_pkg::result_t res,
    output logic                    advance,
    slsfr_out_if.source             out_ch
);

    logic               valid_reg;
    logic               valid_next;
    slsfr_pkg::result_t res_reg;

    // result register can take a new entry when empty or being drained
    assign advance    = !valid_reg || out_ch.ready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.kind         = res_reg.kind;
    assign out_ch.byte_value   = res_reg.byte_value;
    assign out_ch.frame_length = res_reg.frame_length;
    assign out_ch.computed_sum = res_reg.computed_sum;

endmodule

`default_nettype wire

// File: rtl/core/sync_length_sum_frame_receiver.sv
// top level: serial frame receiver with sync bytes, length header and 16-bit sum check
//
//  channel   dir   payload                                         request
//  in_ch     in    rx_byte[7:0]                                    one received byte
//  out_ch    out   kind, byte_value, frame_length, computed_sum    payload byte or frame status
//  cfg       in    cfg_we, cfg_index, cfg_data[7:0]                sync byte write
//
// one byte per cycle sustained while out_ch is not stalled; an accepted byte passes
// the input register and then the result register before any result shows on out_ch
// rst_n clears the frame state and loads sync bytes 0x55 / 0x0F, no clearing pass
// a stall on out_ch holds the result register and backs up into the input register
`default_nettype none

module sync_length_sum_frame_receiver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    slsfr_in_if.sink                               in_ch,
    slsfr_out_if.source                            out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [slsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [slsfr_pkg::BYTE_W-1:0]      cfg_data
);

    logic                         advance;
    logic                         byte_valid;
    logic [slsfr_pkg::BYTE_W-1:0] byte_data;
    logic                         fire;
    logic                         res_valid;
    slsfr_pkg::result_t           res;

    assign fire = byte_valid && advance;

    slsfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    slsfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    slsfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
